FILE: rtl/lr_pkg.sv
// Shared types, constants and the sigmoid table of the logistic-regression scorer.
// Used by lr_front, lr_back and logistic_regression_infer; depends on nothing.
package lr_pkg;

  localparam int MAX_FEATURES = 16;
  localparam int SLOT_W       = $clog2(MAX_FEATURES + 1);
  localparam int WADDR_W      = $clog2(MAX_FEATURES);
  localparam int DATA_W       = 16;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int ACC_W        = 40;
  localparam int FCOUNT_W     = 5;
  localparam int VERSION_W    = 32;
  localparam int PROB_W       = 16;

  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [FCOUNT_W-1:0]  FEATURE_COUNT_RST = FCOUNT_W'(16);
  localparam logic [VERSION_W-1:0] TAG_WORD_RST      = '0;

  // configuration register indexes
  localparam logic CFG_FEATURE_COUNT = 1'b0;
  localparam logic CFG_TAG_WORD      = 1'b1;

  // item kinds
  localparam logic FUNC_WEIGHT  = 1'b0;
  localparam logic FUNC_FEATURE = 1'b1;

  // logit is Q16.24; table covers [-8,8)
  localparam int LOGIT_FRAC = 24;
  localparam int SPAN_LOG2  = LOGIT_FRAC + 3;
  localparam int RANGE_LOG2 = SPAN_LOG2 + 1;
  localparam logic signed [ACC_W-1:0] LOGIT_SPAN = ACC_W'(64'd1 << SPAN_LOG2);

  localparam int SIG_DEPTH = 256;
  localparam int SIG_IDX_W = $clog2(SIG_DEPTH);

  typedef logic [PROB_W-1:0] sig_tab_t [SIG_DEPTH];

  // One queued item, classified by the front end.
  typedef struct packed {
    logic              is_feat;
    logic              wr_ok;     // weight slot in range
    logic [SLOT_W-1:0] slot;      // weight slot, or feature position
    logic [DATA_W-1:0] data;      // weight value or feature value
    logic              first;     // accumulator starts at the bias
    logic              add;       // position below MAX_FEATURES
    logic              last;
    logic              err;       // dimension error on the closing item
  } lr_item_t;

  // unsigned shift-and-subtract division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] dividend,
                                         input logic [63:0] divisor);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], dividend[b]};
      if (rem >= {1'b0, divisor}) begin
        rem    = rem - {1'b0, divisor};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(65536*sigmoid(x)) at each bin center, exp by a 48-term Taylor series in Q24
  function automatic sig_tab_t build_sig_table();
    sig_tab_t    tab;
    logic [63:0] q24_one;
    logic [63:0] span;
    logic [63:0] pos;
    logic [63:0] mag;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] p;
    logic        neg;
    q24_one = 64'd1 << LOGIT_FRAC;
    span    = 64'd1 << SPAN_LOG2;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      pos = (64'(2 * i + 1) * span) >> SIG_IDX_W;
      neg = (pos < span);
      mag = neg ? (span - pos) : (pos - span);
      term = q24_one;
      sum  = q24_one;
      for (int k = 1; k <= 48; k++) begin
        term = (term * mag) >> LOGIT_FRAC;
        term = udiv64(term, 64'(k));
        sum  = sum + term;
      end
      den = sum + q24_one;
      num = neg ? (q24_one << 16) : (sum << 16);
      p   = udiv64(num + (den >> 1), den);
      tab[i] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

FILE: rtl/lr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lr_front.sv
// Front end: accepts input items, tracks the position within the feature vector,
// tags each item and queues it for the back end. Depends on lr_pkg.
module lr_front
  import lr_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [4:0]          in_weight_index,
  input  logic [DATA_W-1:0]   in_weight_value,
  input  logic [DATA_W-1:0]   in_feature_value,
  input  logic                in_last_feature,
  input  logic [FCOUNT_W-1:0] feature_count,
  input  logic                q_pop,
  output logic                q_valid,
  output lr_item_t            q_item
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_FEATURES);

  lr_item_t          queue_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;

  logic              push;
  lr_item_t          item;
  logic [SLOT_W-1:0] cnt_inc;
  logic              ovf_inc;

  assign in_ready = (fill_r != FILL_FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != '0);
  assign q_item   = queue_r[rptr_r];

  // classify the incoming item
  always_comb begin
    item     = '0;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    cnt_inc  = cnt_r;
    ovf_inc  = ovf_r;
    item.is_feat = (in_func == FUNC_FEATURE);
    item.last    = in_last_feature;
    if (in_func == FUNC_WEIGHT) begin
      item.slot  = SLOT_W'(in_weight_index);
      item.wr_ok = (SLOT_W'(in_weight_index) <= SLOT_MAX);
      item.data  = in_weight_value;
    end else begin
      item.slot  = cnt_r;
      item.data  = in_feature_value;
      item.first = (cnt_r == '0);
      item.add   = (cnt_r < SLOT_MAX);
      cnt_inc    = item.add ? cnt_r + SLOT_W'(1) : cnt_r;
      ovf_inc    = ovf_r || !item.add;
      if (in_last_feature) begin
        item.err = ovf_inc || (cnt_inc != SLOT_W'(feature_count));
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
      end else begin
        cnt_nxt  = cnt_inc;
        ovf_nxt  = ovf_inc;
      end
    end
  end

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !q_pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
      if (push) begin
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wptr_r] <= item;
    end
  end

endmodule

FILE: rtl/lr_back.sv
// Back end: weight store, multiply, accumulate, sigmoid lookup and result register.
// Depends on lr_pkg and lr_ram.
module lr_back
  import lr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lr_item_t             q_item,
  output logic                 q_pop,
  input  logic [VERSION_W-1:0] tag_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PROB_W-1:0]    out_probability,
  output logic                 out_class_label,
  output logic [VERSION_W-1:0] out_version_tag,
  output logic                 out_dimension_error
);

  localparam int PROD_EXT = ACC_W - PROD_W;
  localparam int BIAS_EXT = ACC_W - DATA_W - (LOGIT_FRAC - 12);
  localparam logic [SLOT_W-1:0] SLOT_BIAS = SLOT_W'(MAX_FEATURES);

  logic adv;

  // stage B: weight read in flight
  logic              b_valid_r;
  logic [DATA_W-1:0] b_fval_r;
  logic [DATA_W-1:0] b_bias_r;
  logic              b_first_r, b_add_r, b_last_r, b_err_r;
  logic [DATA_W-1:0] w_rdata;

  // stage C: product
  logic              c_valid_r;
  logic [PROD_W-1:0] c_prod_r;
  logic [DATA_W-1:0] c_bias_r;
  logic              c_first_r, c_last_r, c_err_r;

  // accumulator, bias
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [DATA_W-1:0] bias_r;
  logic [ACC_W-1:0]  acc_base;

  // stage D: closed logit
  logic              d_valid_r;
  logic [ACC_W-1:0]  d_logit_r;
  logic              d_err_r;

  // result register
  logic                 out_valid_r;
  logic [PROB_W-1:0]    out_prob_r;
  logic                 out_class_r;
  logic [VERSION_W-1:0] out_version_r;
  logic                 out_err_r;

  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         logit_off;
  logic [SIG_IDX_W-1:0]     sig_idx;
  logic [PROB_W-1:0]        prob;
  logic                     below, above;

  // whole back end moves in lockstep, held while a result waits
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  lr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_FEATURES)
  ) u_wstore (
    .clk   (clk),
    .we    (q_pop && !q_item.is_feat && q_item.wr_ok && (q_item.slot != SLOT_BIAS)),
    .waddr (q_item.slot[WADDR_W-1:0]),
    .wdata (q_item.data),
    .re    (adv),
    .raddr (q_item.slot[WADDR_W-1:0]),
    .rdata (w_rdata)
  );

  assign prod = $signed(b_fval_r) * $signed(w_rdata);

  always_comb begin
    acc_base = c_first_r ? {{BIAS_EXT{c_bias_r[DATA_W-1]}}, c_bias_r, (LOGIT_FRAC - 12)'(0)}
                         : acc_r;
    acc_nxt  = acc_base + {{PROD_EXT{c_prod_r[PROD_W-1]}}, c_prod_r};
  end

  always_comb begin
    below     = $signed(d_logit_r) < -LOGIT_SPAN;
    above     = $signed(d_logit_r) >= LOGIT_SPAN;
    logit_off = d_logit_r + LOGIT_SPAN;
    sig_idx   = logit_off[RANGE_LOG2-1 -: SIG_IDX_W];
    if (d_err_r || below) begin
      prob = '0;
    end else if (above) begin
      prob = '1;
    end else begin
      prob = SIG_TABLE[sig_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (adv) begin
      b_valid_r   <= q_pop && q_item.is_feat;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r && c_last_r;
      out_valid_r <= d_valid_r;
      if (c_valid_r) begin
        acc_r <= c_last_r ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.is_feat && q_item.wr_ok && (q_item.slot == SLOT_BIAS)) begin
      bias_r <= q_item.data;
    end
    if (adv) begin
      b_fval_r      <= q_item.data;
      // bias as it stands when the feature leaves the queue; later loads wait
      b_bias_r      <= bias_r;
      b_first_r     <= q_item.first;
      b_add_r       <= q_item.add;
      b_last_r      <= q_item.last;
      b_err_r       <= q_item.err;
      c_prod_r      <= b_add_r ? PROD_W'(prod) : '0;
      c_bias_r      <= b_bias_r;
      c_first_r     <= b_first_r;
      c_last_r      <= b_last_r;
      c_err_r       <= b_err_r;
      d_logit_r     <= acc_nxt;
      d_err_r       <= c_err_r;
      out_prob_r    <= prob;
      out_class_r   <= !d_err_r && !d_logit_r[ACC_W-1];
      out_version_r <= tag_word;
      out_err_r     <= d_err_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_probability     = out_prob_r;
  assign out_class_label     = out_class_r;
  assign out_version_tag     = out_version_r;
  assign out_dimension_error = out_err_r;

endmodule

FILE: rtl/logistic_regression_infer.sv
// Top level of the logistic-regression scorer: configuration registers,
// front end with item queue, and back end. Depends on lr_pkg, lr_front, lr_back.
//
// Usage:
//   Input channel (in_valid/in_ready): in_func = 0 loads in_weight_value into
//   slot in_weight_index (slot 16 is the bias, higher slots are dropped);
//   in_func = 1 streams one feature, in_last_feature closes the vector.
//   Output channel (out_valid/out_ready): one result per closed vector with the
//   Q0.16 probability, class, version tag and dimension error flag.
//   Config port: cfg_we writes cfg_wdata to register cfg_index
//   (0 feature count, 1 version tag); write only while the block is idle.
//   Throughput: one item per cycle, weights and features alike, while the queue is not full.
//   After its transfer, the closing feature passes the queue, weight read,
//   multiply, accumulate and table lookup before out_valid rises.
//   Reset: clears the queue, pipeline, feature position and accumulator;
//   feature_count returns to 16, the version tag to 0. Weights are undefined
//   until loaded.
//   Receiver stall: the whole back end holds while a result waits; the
//   queue keeps taking items until it is full, then in_ready drops.
module logistic_regression_infer
  import lr_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [4:0]           in_weight_index,
  input  logic [15:0]          in_weight_value,
  input  logic [15:0]          in_feature_value,
  input  logic                 in_last_feature,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_probability,
  output logic                 out_class_label,
  output logic [31:0]          out_version_tag,
  output logic                 out_dimension_error,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_wdata
);

  logic [FCOUNT_W-1:0]  feature_count_r;
  logic [VERSION_W-1:0] tag_word_r;

  logic     q_valid;
  logic     q_pop;
  lr_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_count_r <= FEATURE_COUNT_RST;
      tag_word_r      <= TAG_WORD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEATURE_COUNT: feature_count_r <= cfg_wdata[FCOUNT_W-1:0];
        CFG_TAG_WORD:      tag_word_r      <= cfg_wdata[VERSION_W-1:0];
        default: ;
      endcase
    end
  end

  lr_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_weight_index  (in_weight_index),
    .in_weight_value  (in_weight_value),
    .in_feature_value (in_feature_value),
    .in_last_feature  (in_last_feature),
    .feature_count    (feature_count_r),
    .q_pop            (q_pop),
    .q_valid          (q_valid),
    .q_item           (q_item)
  );

  lr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .tag_word            (tag_word_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_probability     (out_probability),
    .out_class_label     (out_class_label),
    .out_version_tag     (out_version_tag),
    .out_dimension_error (out_dimension_error)
  );

  // an errored result never carries a probability or a class
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dimension_error) |-> (out_probability == '0 && !out_class_label))
    else $error("dimension error result with nonzero probability or class");

  // class 1 means a nonnegative logit, so the probability is at least one half
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_class_label) |-> out_probability[15])
    else $error("class 1 with probability below one half");

  // nothing is presented right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the queue never pops what it does not hold
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

FILE: sim/logistic_regression_infer_tb.sv
// Testbench for logistic_regression_infer: directed table plus random vectors, each result
// checked against an in-bench scorer with its own sigmoid table or fixed directed values.
// Depends on lr_pkg and the logistic_regression_infer RTL.
module logistic_regression_infer_tb;
  import lr_pkg::*;

  localparam int ITEM_GOAL     = 1250;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_MAX    = 10;
  localparam int LUT_DEPTH     = 256;
  localparam longint Q24_ONE   = 64'sd1 << 24;
  localparam longint Q24_EIGHT = 64'sd8 << 24;

  typedef struct packed {
    logic        func;
    logic [4:0]  widx;
    logic [15:0] wval;
    logic [15:0] fval;
    logic        last;
  } lr_req_t;

  typedef struct packed {
    logic [15:0] prob;
    logic        cls;
    logic [31:0] tag;
    logic        derr;
  } score_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        cfg_sel;
    logic [31:0] cfg_val;
    lr_req_t     req;
    bit          fixed;
    score_t      want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [4:0]  in_weight_index;
  logic [15:0] in_weight_value;
  logic [15:0] in_feature_value;
  logic        in_last_feature;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_probability;
  logic        out_class_label;
  logic [31:0] out_version_tag;
  logic        out_dimension_error;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  // scorer state
  logic signed [15:0] wt [0:MAX_FEATURES];
  logic signed [39:0] acc;
  int                 fpos;
  bit                 ovf;
  logic [4:0]         cfg_fcount;
  logic [31:0]        cfg_version;
  logic [15:0]        logistic_lut [0:LUT_DEPTH-1];

  score_t    pending_scores [$];
  plan_row_t directed_plan [$];
  score_t    want_score;
  int        items_done;
  int        scores_seen;
  int        fail_cnt;
  int        burst_left;
  int        stall_cycles;

  logistic_regression_infer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_weight_index    (in_weight_index),
    .in_weight_value    (in_weight_value),
    .in_feature_value   (in_feature_value),
    .in_last_feature    (in_last_feature),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_probability    (out_probability),
    .out_class_label    (out_class_label),
    .out_version_tag    (out_version_tag),
    .out_dimension_error(out_dimension_error),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q0.16 logistic of a Q24 magnitude; exp by a 48-term series, truncating each term
  function automatic logic [15:0] logistic_q16(input longint unsigned mag, input bit neg);
    longint unsigned ex;
    longint unsigned term;
    longint unsigned den;
    longint unsigned num;
    longint unsigned p;
    longint unsigned k;
    ex   = Q24_ONE;
    term = Q24_ONE;
    for (k = 1; k <= 48; k++) begin
      term = ((term * mag) >> 24) / k;
      ex   = ex + term;
    end
    den = ex + Q24_ONE;
    num = neg ? (longint'(Q24_ONE) << 16) : (ex << 16);
    p   = (num + (den >> 1)) / den;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  initial begin : lut_init
    longint unsigned center;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      center = (longint'(2 * i + 1) * Q24_EIGHT) / LUT_DEPTH;
      if (center >= Q24_EIGHT)
        logistic_lut[i] = logistic_q16(center - Q24_EIGHT, 1'b0);
      else
        logistic_lut[i] = logistic_q16(Q24_EIGHT - center, 1'b1);
    end
  end

  // One feature into the running logit; a result comes out on the closing feature.
  function automatic void score_feature(input logic [15:0] fval, input logic last,
                                        output bit got, output score_t res);
    logic signed [31:0] prod;
    longint             lg;
    bit                 derr;
    got = 1'b0;
    res = '0;
    if (fpos == 0 && !ovf) begin
      acc = wt[MAX_FEATURES];
      acc = acc <<< 12;
    end
    if (fpos < MAX_FEATURES) begin
      prod = $signed(fval) * wt[fpos];
      acc  = acc + prod;
      fpos++;
    end else begin
      ovf = 1'b1;
    end
    if (last) begin
      got  = 1'b1;
      derr = ovf || (fpos != int'(cfg_fcount));
      lg   = acc;
      if (derr || lg < -Q24_EIGHT)
        res.prob = '0;
      else if (lg >= Q24_EIGHT)
        res.prob = 16'hFFFF;
      else
        res.prob = logistic_lut[int'(((lg + Q24_EIGHT) * LUT_DEPTH) / (2 * Q24_EIGHT))];
      res.cls  = !derr && lg >= 0;
      res.tag  = cfg_version;
      res.derr = derr;
      acc  = '0;
      fpos = 0;
      ovf  = 1'b0;
    end
  endfunction

  // mostly within +-1.0 so logits land inside the table, with extremes mixed in
  function automatic logic [15:0] rand_q412();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic logic [4:0] pick_slot();
    if ($urandom_range(0, 7) == 0)
      return 5'($urandom_range(MAX_FEATURES + 1, 31));
    return 5'($urandom_range(0, MAX_FEATURES));
  endfunction

  function automatic lr_req_t weight_req(input logic [4:0] idx);
    lr_req_t r;
    r.func = FUNC_WEIGHT;
    r.widx = idx;
    r.wval = rand_q412();
    r.fval = 16'($urandom);
    r.last = 1'($urandom);
    return r;
  endfunction

  function automatic lr_req_t feature_req(input logic last);
    lr_req_t r;
    r.func = FUNC_FEATURE;
    r.widx = 5'($urandom);
    r.wval = 16'($urandom);
    r.fval = rand_q412();
    r.last = last;
    return r;
  endfunction

  function automatic void add_weight(input logic [4:0] idx, input logic [15:0] val);
    plan_row_t row;
    row.kind     = ROW_ITEM;
    row.cfg_sel  = CFG_FEATURE_COUNT;
    row.cfg_val  = '0;
    row.req      = '0;
    row.req.func = FUNC_WEIGHT;
    row.req.widx = idx;
    row.req.wval = val;
    row.fixed    = 1'b0;
    row.want     = '0;
    directed_plan.insert(directed_plan.size(), row);
  endfunction

  function automatic void add_feat(input logic [15:0] val, input logic last, input bit fixed,
                                   input logic [15:0] prob, input logic cls, input logic derr);
    plan_row_t row;
    row.kind      = ROW_ITEM;
    row.cfg_sel   = CFG_FEATURE_COUNT;
    row.cfg_val   = '0;
    row.req       = '0;
    row.req.func  = FUNC_FEATURE;
    row.req.fval  = val;
    row.req.last  = last;
    row.fixed     = fixed;
    row.want      = '0;
    row.want.prob = prob;
    row.want.cls  = cls;
    row.want.derr = derr;
    directed_plan.insert(directed_plan.size(), row);
  endfunction

  function automatic void add_cfg(input logic sel, input logic [31:0] val);
    plan_row_t row;
    row.kind    = ROW_CFG;
    row.cfg_sel = sel;
    row.cfg_val = val;
    row.req     = '0;
    row.fixed   = 1'b0;
    row.want    = '0;
    directed_plan.insert(directed_plan.size(), row);
  endfunction

  // Offer one item in bursts with random gaps; score it at the transfer.
  task automatic send_item(input lr_req_t req, input bit fixed, input score_t want);
    bit     got;
    score_t res;
    int     gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid         = 1'b1;
    in_func          = req.func;
    in_weight_index  = req.widx;
    in_weight_value  = req.wval;
    in_feature_value = req.fval;
    in_last_feature  = req.last;
    do @(posedge clk); while (!in_ready);
    if (req.func == FUNC_WEIGHT) begin
      if (req.widx <= MAX_FEATURES) begin
        wt[req.widx] = req.wval;
        items_done++;
      end
    end else begin
      items_done++;
      score_feature(req.fval, req.last, got, res);
      if (got) begin
        if (fixed) begin
          res.prob = want.prob;
          res.cls  = want.cls;
          res.derr = want.derr;
        end
        pending_scores.insert(pending_scores.size(), res);
      end
    end
  endtask

  // drain: trailing weight items can still sit in the queue after the last result
  task automatic wait_idle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == CFG_FEATURE_COUNT)
      cfg_fcount = val[4:0];
    else
      cfg_version = val;
  endtask

  initial begin : stimulus
    int          phase;
    int          fc;
    int          nvec;
    int          nfeat;
    logic [31:0] ver;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = FUNC_WEIGHT;
    in_weight_index  = '0;
    in_weight_value  = '0;
    in_feature_value = '0;
    in_last_feature  = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_FEATURE_COUNT;
    cfg_wdata        = '0;
    acc              = '0;
    fpos             = 0;
    ovf              = 1'b0;
    cfg_fcount       = FEATURE_COUNT_RST;
    cfg_version      = TAG_WORD_RST;
    items_done       = 0;
    burst_left       = 0;

    // count mismatch right after reset, saturation both ways, table center,
    // ignored slot, short and long vectors, weight change mid-vector, zero count
    add_feat(16'h7FFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1);
    add_cfg(CFG_FEATURE_COUNT, 32'd1);
    add_cfg(CFG_TAG_WORD, 32'hFFFF_FFFF);
    add_weight(5'd31, 16'h1234);
    add_weight(5'd16, 16'h7FFF);
    add_weight(5'd0, 16'h7FFF);
    add_feat(16'h7FFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0);
    add_weight(5'd16, 16'h8000);
    add_feat(16'h8000, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_weight(5'd16, 16'h0000);
    add_weight(5'd0, 16'h0000);
    add_feat(16'h1234, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    add_feat(16'h0001, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_feat(16'h0001, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1);
    add_cfg(CFG_FEATURE_COUNT, 32'd2);
    add_weight(5'd0, 16'h1000);
    add_feat(16'h1000, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_weight(5'd1, 16'hF000);
    add_feat(16'h0800, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    add_cfg(CFG_FEATURE_COUNT, 32'd0);
    add_feat(16'h4000, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1);
    add_cfg(CFG_TAG_WORD, 32'h5A5A_A5A5);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // every slot gets a value before any feature reads it
    for (int s = 0; s <= MAX_FEATURES; s++)
      send_item(weight_req(5'(s)), 1'b0, '0);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_plan[r].cfg_sel, directed_plan[r].cfg_val);
      end else begin
        send_item(directed_plan[r].req, directed_plan[r].fixed, directed_plan[r].want);
      end
    end

    phase = 0;
    while (items_done < ITEM_GOAL) begin
      case (phase)
        0:       fc = 1;
        1:       fc = 16;
        2:       fc = 0;
        3:       fc = 17;
        4:       fc = 31;
        default: fc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(1, 16);
      endcase
      case (phase % 4)
        0:       ver = 32'h0000_0000;
        1:       ver = 32'hFFFF_FFFF;
        default: ver = $urandom;
      endcase
      wait_idle();
      write_reg(CFG_FEATURE_COUNT, {27'($urandom), 5'(fc)});
      write_reg(CFG_TAG_WORD, ver);
      nvec = (fc == 0 || fc > MAX_FEATURES) ? 3 : $urandom_range(4, 12);
      for (int v = 0; v < nvec && items_done < ITEM_GOAL; v++) begin
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 3)) send_item(weight_req(pick_slot()), 1'b0, '0);
        // mostly well-formed vectors; some short, long or overflowing
        case ($urandom_range(0, 7))
          0:       nfeat = fc + 1;
          1:       nfeat = fc - 1;
          2:       nfeat = $urandom_range(1, 20);
          default: nfeat = fc;
        endcase
        if (nfeat < 1) nfeat = 1;
        if (nfeat > 20) nfeat = 20;
        for (int f = 0; f < nfeat; f++) begin
          if (f > 0 && $urandom_range(0, 11) == 0)
            send_item(weight_req(pick_slot()), 1'b0, '0);
          send_item(feature_req(f == nfeat - 1), 1'b0, '0);
        end
      end
      phase++;
    end

    wait_idle();
    if (fail_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // receiver: rotating stall patterns, plus two long hold-offs to back up the queue
  initial begin : receiver
    int cyc;
    int hold_at;
    out_ready = 1'b0;
    cyc       = 0;
    hold_at   = 30;
    forever begin
      @(negedge clk);
      if (scores_seen >= hold_at) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_at = (hold_at == 30) ? 80 : 32'h7FFF_FFFF;
      end
      case ((cyc >> 7) % 4)
        0:       out_ready = 1'b1;
        1:       out_ready = 1'($urandom);
        2:       out_ready = (cyc % 5) != 0;
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
      cyc++;
    end
  end

  initial begin
    scores_seen = 0;
    fail_cnt    = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      scores_seen++;
      if (pending_scores.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("unexpected result transfer: prob %0d class %0d tag %h err %0d",
                   out_probability, out_class_label, out_version_tag, out_dimension_error);
      end else begin
        want_score = pending_scores[0];
        pending_scores.delete(0);
        if (out_probability !== want_score.prob || out_class_label !== want_score.cls ||
            out_version_tag !== want_score.tag || out_dimension_error !== want_score.derr) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("result %0d: exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                     scores_seen, want_score.prob, want_score.cls, want_score.tag,
                     want_score.derr, out_probability, out_class_label, out_version_tag,
                     out_dimension_error);
        end
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
